[sv/multichannel_band_split_filter_top_defines.svh]
// Assertion macros for the band split filter.
`ifndef MULTICHANNEL_BAND_SPLIT_FILTER_TOP_DEFINES_SVH
`define MULTICHANNEL_BAND_SPLIT_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define MBSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define MBSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mbsf_pkg.sv]
// Types, constants and saturation helpers for the band split filter.
package mbsf_pkg;

    localparam int CHANNELS_DEF = 16;

    localparam int CH_W    = 4;
    localparam int SMP_W   = 24;
    localparam int COEF_W  = 32;
    localparam int ST_W    = 48;
    localparam int ACC_W   = 52;
    localparam int PROD_W  = SMP_W + COEF_W;     // x * b
    localparam int XB_W    = PROD_W - 13;        // floor(x * b / 2^13)
    localparam int RH_W    = ST_W - 16;
    localparam int PH_W    = RH_W + COEF_W;      // r_hi * a
    localparam int PL_W    = 17 + COEF_W;        // r_lo * a
    localparam int FULL_W  = 80;                 // exact r * a
    localparam int RA_W    = FULL_W - 30;        // floor(r * a / 2^30)
    localparam int BANDS   = 2;
    localparam int WORD_W  = 2 * ST_W * BANDS;
    localparam int CFG_IDX_W = 3;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_A1      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A2      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_B0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_B1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_B0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_B1 = 3'd5;

    typedef struct packed {
        logic [CH_W-1:0]         channel;
        logic signed [SMP_W-1:0] sample_in;
    } t_in_req;

    typedef struct packed {
        logic signed [SMP_W-1:0] low_band;
        logic signed [SMP_W-1:0] high_band;
    } t_out_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_COMB,
        ST_DONE
    } t_state;

    function automatic logic signed [ST_W-1:0] sat_st(input logic signed [ACC_W-1:0] v);
        if (v[ACC_W-1:ST_W-1] == {(ACC_W-ST_W+1){v[ACC_W-1]}}) begin
            return v[ST_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(ST_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ST_W-1){1'b1}}};
        end
    endfunction

    // v is r / 2^17, 31 bits
    function automatic logic signed [SMP_W-1:0] sat_out(input logic signed [ST_W-18:0] v);
        if (v[ST_W-18:SMP_W-1] == {(ST_W-17-SMP_W+1){v[ST_W-18]}}) begin
            return v[SMP_W-1:0];
        end else if (v[ST_W-18]) begin
            return {1'b1, {(SMP_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SMP_W-1){1'b1}}};
        end
    endfunction

endpackage

[sv/multichannel_band_split_filter_top.sv]
// Multichannel band split filter: two TDF-II biquads per channel, state in one memory.
// A request passes the states SUM, MUL and COMB to DONE, which waits until the output
// register is free: state memory read and chain sum, r * a1/a2 split multiply, product
// combine, state update. The next request is taken in DONE while the last one writes back.
// Reset (synchronous, active low) clears coefficients, per-channel valid flags (state
// reads as zero until written) and control; the state memory itself needs no clearing.
`include "multichannel_band_split_filter_top_defines.svh"

module multichannel_band_split_filter_top #(
    parameter int CHANNELS = mbsf_pkg::CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mbsf_pkg::t_in_req                   i_in_req,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mbsf_pkg::t_out_rsp                  o_out_rsp,
    // coefficient write port
    input  logic                                i_cfg_we,
    input  logic [mbsf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mbsf_pkg::COEF_W-1:0]         i_cfg_data
);
    import mbsf_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // ---------------------------------------------------------------
    // Coefficients. Band 0 is low, band 1 is high.
    // ---------------------------------------------------------------
    logic signed [COEF_W-1:0] r_a1, r_a2;
    logic signed [COEF_W-1:0] r_b0 [BANDS];
    logic signed [COEF_W-1:0] r_b1 [BANDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= '0;
            r_a2 <= '0;
            for (int k = 0; k < BANDS; k++) begin
                r_b0[k] <= '0;
                r_b1[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_A1:      r_a1    <= i_cfg_data;
                CFG_A2:      r_a2    <= i_cfg_data;
                CFG_LOW_B0:  r_b0[0] <= i_cfg_data;
                CFG_LOW_B1:  r_b1[0] <= i_cfg_data;
                CFG_HIGH_B0: r_b0[1] <= i_cfg_data;
                CFG_HIGH_B1: r_b1[1] <= i_cfg_data;
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    t_state r_state, n_state;
    logic   accept;      // request taken this edge
    logic   out_free;    // output register can take a new result
    logic   adv;         // DONE stage completes this edge
    logic   mem_we;

    logic [IDX_W-1:0] in_idx;
    logic             in_rng;

    // State memory: per channel {high s2, high s1, low s2, low s1}.
    // Valid flags stand in for the reset value of zero.
    logic [WORD_W-1:0]   mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;
    logic [WORD_W-1:0]   r_rd_word;
    logic                r_rd_vld;
    logic [WORD_W-1:0]   wr_word;
    logic [IDX_W-1:0]    r_idx;
    logic                r_rng;

    // Output register
    logic     r_out_valid;
    t_out_rsp r_out_rsp;

    assign in_idx = IDX_W'(i_in_req.channel);
    assign in_rng = 32'(i_in_req.channel) < 32'(CHANNELS);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_SUM;
            ST_SUM:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_COMB;
            ST_COMB: n_state = ST_DONE;
            ST_DONE: begin
                if (adv) n_state = accept ? ST_SUM : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        o_in_ready = 1'b0;
        adv        = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_DONE: begin
                // overlap: next request reads memory while this one writes back
                adv        = out_free;
                o_in_ready = out_free;
            end
            default: ;
        endcase
        accept = i_in_valid && o_in_ready;
        mem_we = adv && r_rng;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // State memory
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (mem_we) begin
            r_vld[r_idx] <= 1'b1;
        end
    end

    // Read on accept; forward the write-back when it hits the same channel.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx <= in_idx;
            r_rng <= in_rng;
            if (mem_we && (r_idx == in_idx)) begin
                r_rd_word <= wr_word;
                r_rd_vld  <= 1'b1;
            end else begin
                r_rd_word <= mem[in_idx];
                r_rd_vld  <= r_vld[in_idx];
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath, one lane per band
    // ---------------------------------------------------------------
    logic signed [PROD_W-1:0] r_pb0 [BANDS];
    logic signed [PROD_W-1:0] r_pb1 [BANDS];
    logic signed [ST_W-1:0]   r_r   [BANDS];
    logic signed [XB_W-1:0]   r_xb0 [BANDS];
    logic signed [XB_W-1:0]   r_xb1 [BANDS];
    logic signed [ST_W-1:0]   r_s2  [BANDS];
    logic signed [PH_W-1:0]   r_ph1 [BANDS];
    logic signed [PH_W-1:0]   r_ph2 [BANDS];
    logic signed [PL_W-1:0]   r_pl1 [BANDS];
    logic signed [PL_W-1:0]   r_pl2 [BANDS];
    logic signed [RA_W-1:0]   r_ra1 [BANDS];
    logic signed [RA_W-1:0]   r_ra2 [BANDS];

    logic signed [ST_W-1:0]   s1_rd [BANDS];
    logic signed [ST_W-1:0]   s2_rd [BANDS];
    logic signed [ST_W-1:0]   r_new [BANDS];
    logic signed [RH_W-1:0]   r_hi  [BANDS];
    logic signed [16:0]       r_lo  [BANDS];
    logic signed [FULL_W-1:0] full1 [BANDS];
    logic signed [FULL_W-1:0] full2 [BANDS];
    logic signed [ST_W-1:0]   n1    [BANDS];
    logic signed [ST_W-1:0]   n2    [BANDS];
    logic signed [SMP_W-1:0]  band_out [BANDS];

    always_comb begin
        for (int k = 0; k < BANDS; k++) begin
            // a channel never written reads as zero
            s1_rd[k] = r_rd_vld ? r_rd_word[2*ST_W*k +: ST_W] : '0;
            s2_rd[k] = r_rd_vld ? r_rd_word[2*ST_W*k + ST_W +: ST_W] : '0;
            r_new[k] = sat_st(ACC_W'($signed(r_pb0[k][PROD_W-1:13])) + ACC_W'(s1_rd[k]));
            r_hi[k]  = r_r[k][ST_W-1:16];
            r_lo[k]  = $signed({1'b0, r_r[k][15:0]});
            full1[k] = (FULL_W'(r_ph1[k]) <<< 16) + FULL_W'(r_pl1[k]);
            full2[k] = (FULL_W'(r_ph2[k]) <<< 16) + FULL_W'(r_pl2[k]);
            n1[k]    = sat_st(ACC_W'(r_xb1[k]) - ACC_W'(r_ra1[k]) + ACC_W'(r_s2[k]));
            n2[k]    = sat_st(ACC_W'(r_xb0[k]) - ACC_W'(r_ra2[k]));
            band_out[k] = sat_out(r_r[k][ST_W-1:17]);
            wr_word[2*ST_W*k +: ST_W]        = n1[k];
            wr_word[2*ST_W*k + ST_W +: ST_W] = n2[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < BANDS; k++) begin
            // feedforward products on accept
            if (accept) begin
                r_pb0[k] <= i_in_req.sample_in * r_b0[k];
                r_pb1[k] <= i_in_req.sample_in * r_b1[k];
            end
            // r = sat(x*b0 + s1)
            if (r_state == ST_SUM) begin
                r_r[k]   <= r_new[k];
                r_xb0[k] <= r_pb0[k][PROD_W-1:13];
                r_xb1[k] <= r_pb1[k][PROD_W-1:13];
                r_s2[k]  <= s2_rd[k];
            end
            // r * a split into high and low halves
            if (r_state == ST_MUL) begin
                r_ph1[k] <= r_hi[k] * r_a1;
                r_ph2[k] <= r_hi[k] * r_a2;
                r_pl1[k] <= r_lo[k] * r_a1;
                r_pl2[k] <= r_lo[k] * r_a2;
            end
            // floor(r * a / 2^30)
            if (r_state == ST_COMB) begin
                r_ra1[k] <= full1[k][FULL_W-1:30];
                r_ra2[k] <= full2[k][FULL_W-1:30];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // channel outside the memory: zeros, state untouched
            r_out_rsp.low_band  <= r_rng ? band_out[0] : '0;
            r_out_rsp.high_band <= r_rng ? band_out[1] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `MBSF_ASSERT_NXT(a_accept_starts, accept, r_state == ST_SUM, "accepted request did not start")
    `MBSF_ASSERT_IMP(a_no_overwrite, o_out_valid && !i_out_ready, !adv, "pending result overwritten")
    `MBSF_ASSERT_NXT(a_oor_zero, adv && !r_rng, o_out_rsp == '0, "out-of-range channel not zero")

endmodule

[tb/tb_multichannel_band_split_filter_top.sv]
// Self-checking testbench for the multichannel band split filter top level.
module tb_multichannel_band_split_filter_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbsf_pkg::*;

    // Run-level constants
    localparam int N_CHANNELS       = CHANNELS_DEF;
    localparam int WIDE             = 128;  // headroom for every exact product
    localparam int LOW_BAND         = 0;
    localparam int HIGH_BAND        = 1;
    localparam int DRAIN_CYCLES     = 8;    // extra idle wait after the last result
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int MAX_REPORTS      = 10;

    // Register indexes past the map; writes to these must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic signed [WIDE-1:0] WIDE_ST_MAX  = 128'sh7FFF_FFFF_FFFF;
    localparam logic signed [WIDE-1:0] WIDE_ST_MIN  = -WIDE_ST_MAX - 1;
    localparam logic signed [WIDE-1:0] WIDE_OUT_MAX = 128'sh7F_FFFF;
    localparam logic signed [WIDE-1:0] WIDE_OUT_MIN = -WIDE_OUT_MAX - 1;

    localparam logic signed [SMP_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
    localparam logic signed [SMP_W-1:0] SAMPLE_MIN = 24'sh80_0000;

    localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

    // Crossover A: poles at 0.8 +/- 0.1j, unity gain at DC (low) and Nyquist (high)
    localparam logic [COEF_W-1:0] XA_A1  = -32'sd1717986918;   // -1.6
    localparam logic [COEF_W-1:0] XA_A2  = 32'sd697932186;     //  0.65
    localparam logic [COEF_W-1:0] XA_LB0 = 32'sd13421773;      //  0.0125
    localparam logic [COEF_W-1:0] XA_LB1 = 32'sd26843546;      //  0.025
    localparam logic [COEF_W-1:0] XA_HB0 = 32'sd872415232;     //  0.8125
    localparam logic [COEF_W-1:0] XA_HB1 = -32'sd1744830464;   // -1.625
    // Crossover B: double pole at 0.5
    localparam logic [COEF_W-1:0] XB_A1  = -32'sd1073741824;   // -1.0
    localparam logic [COEF_W-1:0] XB_A2  = 32'sd268435456;     //  0.25
    localparam logic [COEF_W-1:0] XB_LB0 = 32'sd67108864;      //  0.0625
    localparam logic [COEF_W-1:0] XB_LB1 = 32'sd134217728;     //  0.125
    localparam logic [COEF_W-1:0] XB_HB0 = 32'sd603979776;     //  0.5625
    localparam logic [COEF_W-1:0] XB_HB1 = -32'sd1207959552;   // -1.125

    // Predictor of both bands plus the FIFO of expected results
    class band_split_checker;
        logic signed [COEF_W-1:0] fb_one;
        logic signed [COEF_W-1:0] fb_two;
        logic signed [COEF_W-1:0] ff_zero [BANDS];
        logic signed [COEF_W-1:0] ff_one  [BANDS];
        logic signed [ST_W-1:0]   st_one  [BANDS][N_CHANNELS];
        logic signed [ST_W-1:0]   st_two  [BANDS][N_CHANNELS];
        t_out_rsp                 expected_bands [$];
        int                       mismatches;

        function new();
            fb_one = '0;
            fb_two = '0;
            foreach (ff_zero[b]) begin
                ff_zero[b] = '0;
                ff_one[b]  = '0;
            end
            foreach (st_one[b, c]) begin
                st_one[b][c] = '0;
                st_two[b][c] = '0;
            end
            mismatches = 0;
        endfunction

        function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            case (idx)
                CFG_A1:      fb_one      = data;
                CFG_A2:      fb_two      = data;
                CFG_LOW_B0:  ff_zero[LOW_BAND]  = data;
                CFG_LOW_B1:  ff_one[LOW_BAND]   = data;
                CFG_HIGH_B0: ff_zero[HIGH_BAND] = data;
                CFG_HIGH_B1: ff_one[HIGH_BAND]  = data;
                default: ;
            endcase
        endfunction

        function logic signed [WIDE-1:0] saturate(logic signed [WIDE-1:0] v,
                                                  logic signed [WIDE-1:0] lo,
                                                  logic signed [WIDE-1:0] hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // One TDF-II section; >>> on signed values floors
        function logic signed [SMP_W-1:0] split_band(int bnd, int ch,
                                                     logic signed [WIDE-1:0] x);
            logic signed [WIDE-1:0] b0, b1, a1, a2, xb0, xb1, r, n1, n2, o;
            b0  = ff_zero[bnd];
            b1  = ff_one[bnd];
            a1  = fb_one;
            a2  = fb_two;
            xb0 = (x * b0) >>> 13;
            xb1 = (x * b1) >>> 13;
            r   = saturate(xb0 + st_one[bnd][ch], WIDE_ST_MIN, WIDE_ST_MAX);
            n1  = saturate(xb1 - ((r * a1) >>> 30) + st_two[bnd][ch],
                           WIDE_ST_MIN, WIDE_ST_MAX);
            n2  = saturate(xb0 - ((r * a2) >>> 30), WIDE_ST_MIN, WIDE_ST_MAX);
            st_one[bnd][ch] = n1[ST_W-1:0];
            st_two[bnd][ch] = n2[ST_W-1:0];
            o   = saturate(r >>> 17, WIDE_OUT_MIN, WIDE_OUT_MAX);
            return o[SMP_W-1:0];
        endfunction

        function void note_request(t_in_req req);
            t_out_rsp               rsp;
            logic signed [WIDE-1:0] x;
            x = $signed(req.sample_in);
            if (int'(req.channel) >= N_CHANNELS) begin
                rsp = '0;
            end else begin
                rsp.low_band  = split_band(LOW_BAND,  int'(req.channel), x);
                rsp.high_band = split_band(HIGH_BAND, int'(req.channel), x);
            end
            expected_bands.push_back(rsp);
        endfunction

        function void report(string what, logic signed [SMP_W-1:0] want,
                             logic signed [SMP_W-1:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
            end
        endfunction

        function void check_result(t_out_rsp got);
            t_out_rsp want;
            if (expected_bands.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] unexpected result: low %0d high %0d",
                             $time, got.low_band, got.high_band);
                end
                return;
            end
            want = expected_bands.pop_front();
            if (got.low_band !== want.low_band) begin
                report("low_band", want.low_band, got.low_band);
            end
            if (got.high_band !== want.high_band) begin
                report("high_band", want.high_band, got.high_band);
            end
        endfunction

        function int pending();
            return expected_bands.size();
        endfunction
    endclass

    // DUT-facing signals
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_req              i_in_req;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_rsp             o_out_rsp;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    // Idling controls shared between the request and result processes
    bit src_idling   = 1'b0;
    bit sink_idling  = 1'b0;
    bit hold_request = 1'b0;  // asks the result side for one long hold-off
    bit sink_holding = 1'b0;  // high while that hold-off runs

    band_split_checker band_board = new();

    multichannel_band_split_filter_top #(
        .CHANNELS(N_CHANNELS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends the run well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Monitor: both handshakes are sampled on the rising edge. The result is
    // checked before the request is noted; the FIFO keeps them in order anyway.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                band_board.check_result(o_out_rsp);
            end
            if (i_in_valid && o_in_ready) begin
                band_board.note_request(i_in_req);
            end
        end
    end

    // Result side: ready drops in short random bursts while idling is on,
    // and once for a long hold-off so the pipeline backs up into the request side.
    initial begin : result_sink
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                sink_holding = 1'b1;
                i_out_ready  = 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
                sink_holding = 1'b0;
            end else if (sink_idling && $urandom_range(0, 5) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // Coefficient write; called on a falling edge, returns on the next one
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COEF_W-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        band_board.write_coef(idx, data);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic apply_setting(input logic [COEF_W-1:0] a1, input logic [COEF_W-1:0] a2,
                                 input logic [COEF_W-1:0] lb0, input logic [COEF_W-1:0] lb1,
                                 input logic [COEF_W-1:0] hb0, input logic [COEF_W-1:0] hb1);
        write_register(CFG_A1,      a1);
        write_register(CFG_A2,      a2);
        write_register(CFG_LOW_B0,  lb0);
        write_register(CFG_LOW_B1,  lb1);
        write_register(CFG_HIGH_B0, hb0);
        write_register(CFG_HIGH_B1, hb1);
    endtask

    // Coefficients only change once every result is back and the pipe is empty
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (band_board.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Offer one request and hold it until taken. Entered and left on a falling
    // edge, so valid stays high between back-to-back requests.
    task automatic send_request(input logic [CH_W-1:0] ch, input logic signed [SMP_W-1:0] smp);
        t_in_req req;
        if (src_idling && !sink_holding && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        req.channel   = ch;
        req.sample_in = smp;
        i_in_req      = req;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly full-scale noise, with rails, tiny values and 0/-1 mixed in
    function automatic logic signed [SMP_W-1:0] random_sample();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SMP_W'($signed(raw[8:0]));
            3:       return {SMP_W{raw[0]}};
            default: return raw[SMP_W-1:0];
        endcase
    endfunction

    // Random requests; channels come singly or in runs so a slot's state builds up
    task automatic run_random(input int count, input bit with_pressure);
        logic [CH_W-1:0] ch;
        int              run_left;
        run_left = 0;
        ch       = '0;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                ch       = CH_W'($urandom_range(0, (1 << CH_W) - 1));
                run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 24) : 1;
            end
            run_left--;
            if (with_pressure && n == count / 4) begin
                hold_request = 1'b1;
            end
            send_request(ch, random_sample());
        end
    endtask

    initial begin : stimulus
        logic signed [SMP_W-1:0] edge_samples [8];

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        edge_samples = '{SAMPLE_MAX, SAMPLE_MIN, 24'sd0, -24'sd1, 24'sd1,
                         24'sh55_5555, 24'shAA_AAAA, 24'sh00_FFFF};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset coefficients are zero: both bands must come back silent
        send_request(4'd0,  SAMPLE_MAX);
        send_request(4'd15, SAMPLE_MIN);
        wait_idle();

        apply_setting(XA_A1, XA_A2, XA_LB0, XA_LB1, XA_HB0, XA_HB1);
        // Spare indexes: must leave every coefficient alone
        write_register(CFG_SPARE_LO, $urandom());
        write_register(CFG_SPARE_HI, $urandom());

        // Every channel once, with rail and bit-pattern samples
        for (int c = 0; c < (1 << CH_W); c++) begin
            send_request(c[CH_W-1:0], edge_samples[c % 8]);
        end
        // Step up then hard reversal on one slot: state carried across requests
        send_request(4'd3, SAMPLE_MAX);
        send_request(4'd3, SAMPLE_MAX);
        send_request(4'd3, SAMPLE_MIN);
        send_request(4'd3, SAMPLE_MIN);
        send_request(4'd3, 24'sd0);
        wait_idle();

        // Realistic crossover, idling on both sides, one long result hold-off
        src_idling  = 1'b1;
        sink_idling = 1'b1;
        run_random(280, 1'b1);
        wait_idle();

        // All coefficients at the positive rail: state and outputs saturate
        apply_setting(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        run_random(220, 1'b0);
        wait_idle();

        // Negative rail, back-to-back with no idling
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        apply_setting(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        run_random(220, 1'b0);
        wait_idle();

        // Mixed rails
        src_idling  = 1'b1;
        sink_idling = 1'b1;
        apply_setting(COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
        run_random(220, 1'b0);
        wait_idle();

        // Second stable crossover; saturated state from above decays out
        apply_setting(XB_A1, XB_A2, XB_LB0, XB_LB1, XB_HB0, XB_HB1);
        run_random(280, 1'b0);
        wait_idle();

        // Arbitrary coefficient words
        apply_setting($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        run_random(280, 1'b0);
        wait_idle();

        // Closing stretch without idling
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        apply_setting(XA_A1, XA_A2, XA_LB0, XA_LB1, XA_HB0, XA_HB1);
        run_random(330, 1'b0);
        i_in_valid = 1'b0;

        while (band_board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (band_board.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
